@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is held.
`define EQBT_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also applies while reset is held.
`define EQBT_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/eqbt_pkg.sv @@
// ----------------------------------------------------------------------------
// eqbt_pkg
// Types, constants and helper functions shared by the Euler-to-quaternion
// body twist pipeline.
// ----------------------------------------------------------------------------
package eqbt_pkg;

  // Default number of CORDIC micro-rotations.
  localparam int CORDIC_STAGES_DEF = 16;
  // Number of tabulated arctangent entries.
  localparam int ATAN_TAPS = 24;

  // CORDIC datapath width (Q30 with growth and sign).
  localparam int CW = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

  // Degree-to-turn conversion: h = 46603 * m + floor((34 * m + 45) / 90).
  localparam logic [15:0] ANG_K1    = 16'd46603;
  localparam logic [5:0]  ANG_REM   = 6'd34;
  localparam logic [5:0]  ANG_HALF  = 6'd45;
  localparam logic [20:0] ANG_RECIP = 21'd1491309;
  localparam int          ANG_SH    = 27;

  // Degrees per second to rad/s scale, split as RATE_HI * 2^17 + RATE_LO.
  localparam logic signed [17:0] RATE_HI = 18'sd73204;
  localparam logic signed [16:0] RATE_LO = 17'sd54346;

  // Widths of the vector rotation datapath.
  localparam int VW  = 32;   // input vector components
  localparam int QRW = 27;   // quaternion components in Q24
  localparam int TW  = 32;   // intermediate t terms

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
  } vec3_t;

  typedef struct packed {
    logic signed [QRW-1:0] x;
    logic signed [QRW-1:0] y;
    logic signed [QRW-1:0] z;
    logic signed [QRW-1:0] w;
  } quat_t;

  // Arctangent of 2^-idx in binary-angle units (2^32 per turn).
  function automatic logic signed [CW-1:0] atan_turn(input int idx);
    logic signed [CW-1:0] r;
    case (idx)
      0:  r = 34'sh020000000;
      1:  r = 34'sh012E4051E;
      2:  r = 34'sh009FB385B;
      3:  r = 34'sh0051111D4;
      4:  r = 34'sh0028B0D43;
      5:  r = 34'sh00145D7E1;
      6:  r = 34'sh000A2F61E;
      7:  r = 34'sh000517C55;
      8:  r = 34'sh00028BE53;
      9:  r = 34'sh000145F2F;
      10: r = 34'sh0000A2F98;
      11: r = 34'sh0000517CC;
      12: r = 34'sh000028BE6;
      13: r = 34'sh0000145F3;
      14: r = 34'sh00000A2FA;
      15: r = 34'sh00000517D;
      16: r = 34'sh0000028BE;
      17: r = 34'sh00000145F;
      18: r = 34'sh000000A30;
      19: r = 34'sh000000518;
      20: r = 34'sh00000028C;
      21: r = 34'sh000000146;
      22: r = 34'sh0000000A3;
      23: r = 34'sh000000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Product of two Q30 values, rounded half up back to Q30.
  function automatic logic signed [CW-1:0] mul_q30(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
    logic signed [2*CW-1:0] p;
    p = ((2*CW)'(a) * (2*CW)'(b)) + ((2*CW)'(1) <<< 29);
    return CW'(p >>> 30);
  endfunction

endpackage

@@ src/euler_to_quaternion_body_twist_unit.sv @@
// ----------------------------------------------------------------------------
// euler_to_quaternion_body_twist_unit
// Converts a left-handed pose sample to a ZYX quaternion and rotates the
// world linear and angular velocities into the body frame.
// ----------------------------------------------------------------------------
// Usage.
// A transaction is taken at a rising edge where start is high and busy is
// low. The payload is roll, pitch and yaw plus the world velocity and rate
// vectors, each on a port of its own. busy is high only while rst is held,
// so outside reset a new sample can be started on every clock cycle.
// Each sample yields one result: quaternion in Q1.15, body velocity and body
// rate. The result stands on the output ports for exactly one cycle, marked
// by done. Throughput is one sample per cycle. The pipeline is made of the
// per-stage CORDIC chain, two stages of angle conversion, three of quaternion
// products and four of vector rotation. Synchronous reset clears every valid
// bit, so samples in flight are dropped and done stays low until new samples
// reach the end. The receiver cannot hold results off; the pipeline never
// stalls.
// ----------------------------------------------------------------------------
module euler_to_quaternion_body_twist_unit #(
  parameter int CORDIC_STAGES = eqbt_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] roll_deg,
  input  logic signed [15:0] pitch_deg,
  input  logic signed [15:0] yaw_deg,
  input  logic signed [16:0] vel_x,
  input  logic signed [16:0] vel_y,
  input  logic signed [16:0] vel_z,
  input  logic signed [17:0] rate_x,
  input  logic signed [17:0] rate_y,
  input  logic signed [17:0] rate_z,
  output logic               done,
  output logic signed [15:0] quat_x,
  output logic signed [15:0] quat_y,
  output logic signed [15:0] quat_z,
  output logic signed [15:0] quat_w,
  output logic signed [17:0] body_vel_x,
  output logic signed [17:0] body_vel_y,
  output logic signed [17:0] body_vel_z,
  output logic signed [19:0] body_rate_x,
  output logic signed [19:0] body_rate_y,
  output logic signed [19:0] body_rate_z
);
  import eqbt_pkg::*;

  localparam int N   = CORDIC_STAGES;
  localparam int LAT = N + 9;
  localparam int SW  = CW + 1;

  // Valid bits and control.
  logic [LAT-1:0] vld;
  logic           accept;

  // Stage A: angle and rate products.
  logic signed [16:0] ang_s [3];
  logic        [16:0] ang_m [3];
  logic        [20:0] ang_t [3];
  logic        [32:0] a_p1  [3];
  logic        [41:0] a_p2  [3];
  logic               a_neg [3];
  logic signed [18:0] rate_n [3];
  logic signed [36:0] r_ph  [3];
  logic signed [36:0] r_pl  [3];
  vec3_t              va;

  // Stage B: folded angles and scaled rates.
  logic        [31:0] ang_q [3];
  logic        [31:0] ang_h [3];
  logic               ang_f [3];
  logic signed [63:0] rate_sum [3];
  vec3_t              wb;

  // CORDIC chain: start registers, then one output set per micro-rotation.
  logic signed [CW-1:0] cx0 [3];
  logic signed [CW-1:0] cy0 [3];
  logic signed [CW-1:0] cz0 [3];
  logic signed [CW-1:0] cx [N][3];
  logic signed [CW-1:0] cy [N][3];
  logic signed [CW-1:0] cz [N][3];
  logic [2:0]           flip_d [N+1];
  vec3_t                v_pipe [N+4];
  vec3_t                w_pipe [N+4];

  // Quaternion products.
  logic signed [CW-1:0] cos_h [3];
  logic signed [CW-1:0] sin_h [3];
  logic signed [CW-1:0] m_a, m_b, m_c, m_d, m_cy, m_sy;
  logic signed [CW-1:0] p_wa, p_wb, p_za, p_zb, p_xa, p_xb, p_ya, p_yb;
  logic signed [SW-1:0] q_sum [4];
  logic signed [SW-1:0] q_r15 [4];
  logic signed [SW-1:0] q_r24 [4];
  logic signed [15:0]   q_o15 [4];
  logic signed [15:0]   qo [4];
  logic signed [15:0]   qo_d [4][4];
  quat_t                q24;

  assign accept = start && !busy;
  assign busy   = rst;
  assign done   = vld[LAT-1];

  // Valid bits move one stage per cycle alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], accept};
    end
  end

  // Stage A: negate pitch, yaw, vel_y and the y and z rates; take magnitudes; form products.
  always_comb begin
    ang_s[0]  = 17'(roll_deg);
    ang_s[1]  = -17'(pitch_deg);
    ang_s[2]  = -17'(yaw_deg);
    rate_n[0] = 19'(rate_x);
    rate_n[1] = -19'(rate_y);
    rate_n[2] = -19'(rate_z);
    for (int k = 0; k < 3; k++) begin
      ang_m[k] = ang_s[k][16] ? 17'(-ang_s[k]) : 17'(ang_s[k]);
      ang_t[k] = 21'(ang_m[k]) * 21'(ANG_REM) + 21'(ANG_HALF);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      a_p1[k]  <= 33'(ang_m[k]) * 33'(ANG_K1);
      a_p2[k]  <= 42'(ang_t[k]) * 42'(ANG_RECIP);
      a_neg[k] <= ang_s[k][16];
      r_ph[k]  <= 37'(rate_n[k]) * 37'(RATE_HI);
      r_pl[k]  <= 37'(rate_n[k]) * 37'(RATE_LO);
    end
    va.x <= VW'(vel_x) <<< 8;
    va.y <= -(VW'(vel_y) <<< 8);
    va.z <= VW'(vel_z) <<< 8;
  end

  // Stage B: half angle in turns, quadrant fold, rate scaling.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ang_q[k] = 32'(a_p1[k] + 33'(a_p2[k] >> ANG_SH));
      ang_h[k] = a_neg[k] ? -ang_q[k] : ang_q[k];
      ang_f[k] = ang_h[k][31] ^ ang_h[k][30];
      rate_sum[k] = (64'(r_ph[k]) <<< 17) + 64'(r_pl[k]) + (64'sd1 <<< 23);
    end
    wb.x = VW'(rate_sum[0] >>> 24);
    wb.y = VW'(rate_sum[1] >>> 24);
    wb.z = VW'(rate_sum[2] >>> 24);
  end

  // CORDIC start values; side data and fold flags travel alongside the chain.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      cx0[k]       <= CORDIC_GAIN;
      cy0[k]       <= '0;
      cz0[k]       <= CW'(signed'({ang_h[k][31] ^ ang_f[k], ang_h[k][30:0]}));
      flip_d[0][k] <= ang_f[k];
    end
    v_pipe[0] <= va;
    w_pipe[0] <= wb;
    for (int i = 1; i <= N; i++) begin
      flip_d[i] <= flip_d[i-1];
    end
    for (int i = 1; i < N + 4; i++) begin
      v_pipe[i] <= v_pipe[i-1];
      w_pipe[i] <= w_pipe[i-1];
    end
  end

  // CORDIC micro-rotations, one register stage each, for the three angles.
  for (genvar i = 0; i < N; i++) begin : g_stage
    for (genvar k = 0; k < 3; k++) begin : g_axis
      logic signed [CW-1:0] xi, yi, zi;
      if (i == 0) begin : g_first
        assign xi = cx0[k];
        assign yi = cy0[k];
        assign zi = cz0[k];
      end else begin : g_next
        assign xi = cx[i-1][k];
        assign yi = cy[i-1][k];
        assign zi = cz[i-1][k];
      end
      eqbt_cordic_stage #(
        .STAGE (i)
      ) u_stage (
        .clk   (clk),
        .x_in  (xi),
        .y_in  (yi),
        .z_in  (zi),
        .x_out (cx[i][k]),
        .y_out (cy[i][k]),
        .z_out (cz[i][k])
      );
    end
  end

  // Undo the quadrant fold on the CORDIC outputs.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cos_h[k] = flip_d[N][k] ? -cx[N-1][k] : cx[N-1][k];
      sin_h[k] = flip_d[N][k] ? -cy[N-1][k] : cy[N-1][k];
    end
  end

  // First quaternion products of roll and pitch terms.
  always_ff @(posedge clk) begin
    m_a  <= mul_q30(cos_h[0], cos_h[1]);
    m_b  <= mul_q30(sin_h[0], sin_h[1]);
    m_c  <= mul_q30(sin_h[0], cos_h[1]);
    m_d  <= mul_q30(cos_h[0], sin_h[1]);
    m_cy <= cos_h[2];
    m_sy <= sin_h[2];
  end

  // Products with the yaw terms.
  always_ff @(posedge clk) begin
    p_wa <= mul_q30(m_a, m_cy);
    p_wb <= mul_q30(m_b, m_sy);
    p_za <= mul_q30(m_a, m_sy);
    p_zb <= mul_q30(m_b, m_cy);
    p_xa <= mul_q30(m_c, m_cy);
    p_xb <= mul_q30(m_d, m_sy);
    p_ya <= mul_q30(m_d, m_cy);
    p_yb <= mul_q30(m_c, m_sy);
  end

  // Components in order x, y, z, w; rounded to Q15 (saturated) and Q24.
  always_comb begin
    q_sum[0] = SW'(p_xa) - SW'(p_xb);
    q_sum[1] = SW'(p_ya) + SW'(p_yb);
    q_sum[2] = SW'(p_za) - SW'(p_zb);
    q_sum[3] = SW'(p_wa) + SW'(p_wb);
    for (int k = 0; k < 4; k++) begin
      q_r15[k] = (q_sum[k] + (SW'(1) <<< 14)) >>> 15;
      q_r24[k] = (q_sum[k] + (SW'(1) <<< 5)) >>> 6;
      if (q_r15[k] > SW'(32767)) begin
        q_o15[k] = 16'sd32767;
      end else if (q_r15[k] < -SW'(32767)) begin
        q_o15[k] = -16'sd32767;
      end else begin
        q_o15[k] = 16'(q_r15[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      qo[k] <= q_o15[k];
    end
    q24.x <= QRW'(q_r24[0]);
    q24.y <= QRW'(q_r24[1]);
    q24.z <= QRW'(q_r24[2]);
    q24.w <= QRW'(q_r24[3]);
  end

  // Hold the Q15 quaternion while the vectors are rotated.
  always_ff @(posedge clk) begin
    qo_d[0] <= qo;
    for (int i = 1; i < 4; i++) begin
      qo_d[i] <= qo_d[i-1];
    end
  end

  assign quat_x = qo_d[3][0];
  assign quat_y = qo_d[3][1];
  assign quat_z = qo_d[3][2];
  assign quat_w = qo_d[3][3];

  // Body-frame linear velocity.
  eqbt_rotate #(
    .OUT_W (18)
  ) u_rot_vel (
    .clk (clk),
    .q   (q24),
    .v   (v_pipe[N+3]),
    .ox  (body_vel_x),
    .oy  (body_vel_y),
    .oz  (body_vel_z)
  );

  // Body-frame angular velocity.
  eqbt_rotate #(
    .OUT_W (20)
  ) u_rot_rate (
    .clk (clk),
    .q   (q24),
    .v   (w_pipe[N+3]),
    .ox  (body_rate_x),
    .oy  (body_rate_y),
    .oz  (body_rate_z)
  );

endmodule

@@ src/eqbt_cordic_stage.sv @@
// ----------------------------------------------------------------------------
// eqbt_cordic_stage
// One registered rotation-mode CORDIC micro-rotation.
// ----------------------------------------------------------------------------
module eqbt_cordic_stage #(
  parameter int STAGE = 0
) (
  input  logic                             clk,
  input  logic signed [eqbt_pkg::CW-1:0]   x_in,
  input  logic signed [eqbt_pkg::CW-1:0]   y_in,
  input  logic signed [eqbt_pkg::CW-1:0]   z_in,
  output logic signed [eqbt_pkg::CW-1:0]   x_out,
  output logic signed [eqbt_pkg::CW-1:0]   y_out,
  output logic signed [eqbt_pkg::CW-1:0]   z_out
);
  import eqbt_pkg::*;

  localparam logic signed [CW-1:0] ATAN = atan_turn(STAGE);

  // Rotate towards zero residual angle; stages past the table pass through.
  always_ff @(posedge clk) begin
    if (STAGE >= ATAN_TAPS) begin
      x_out <= x_in;
      y_out <= y_in;
      z_out <= z_in;
    end else if (!z_in[CW-1]) begin
      x_out <= x_in - (y_in >>> STAGE);
      y_out <= y_in + (x_in >>> STAGE);
      z_out <= z_in - ATAN;
    end else begin
      x_out <= x_in + (y_in >>> STAGE);
      y_out <= y_in - (x_in >>> STAGE);
      z_out <= z_in + ATAN;
    end
  end

endmodule

@@ src/eqbt_rotate.sv @@
// ----------------------------------------------------------------------------
// eqbt_rotate
// Four-stage pipeline that rotates a vector by conj(q) * v * q.
// ----------------------------------------------------------------------------
module eqbt_rotate #(
  parameter int OUT_W = 18
) (
  input  logic                    clk,
  input  eqbt_pkg::quat_t         q,
  input  eqbt_pkg::vec3_t         v,
  output logic signed [OUT_W-1:0] ox,
  output logic signed [OUT_W-1:0] oy,
  output logic signed [OUT_W-1:0] oz
);
  import eqbt_pkg::*;

  localparam int P1W = QRW + VW;
  localparam int S2W = P1W + 2;
  localparam int P3W = TW + QRW;
  localparam int S4W = P3W + 2;
  localparam logic signed [S4W-1:0] HI = S4W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [S4W-1:0] LO = -HI - S4W'(1);

  logic signed [P1W-1:0] p1 [12];
  quat_t                 q1;
  logic signed [TW-1:0]  t0, t1, t2, t3;
  quat_t                 q2;
  logic signed [P3W-1:0] p3 [12];
  logic signed [S2W-1:0] s2 [4];
  logic signed [S4W-1:0] s4 [3];
  logic signed [S4W-1:0] r4 [3];
  logic signed [OUT_W-1:0] o4 [3];

  // First products of the quaternion with the vector.
  always_ff @(posedge clk) begin
    p1[0]  <= P1W'(q.w) * P1W'(v.x);
    p1[1]  <= P1W'(q.y) * P1W'(v.z);
    p1[2]  <= P1W'(q.z) * P1W'(v.y);
    p1[3]  <= P1W'(q.w) * P1W'(v.y);
    p1[4]  <= P1W'(q.z) * P1W'(v.x);
    p1[5]  <= P1W'(q.x) * P1W'(v.z);
    p1[6]  <= P1W'(q.w) * P1W'(v.z);
    p1[7]  <= P1W'(q.x) * P1W'(v.y);
    p1[8]  <= P1W'(q.y) * P1W'(v.x);
    p1[9]  <= P1W'(q.x) * P1W'(v.x);
    p1[10] <= P1W'(q.y) * P1W'(v.y);
    p1[11] <= P1W'(q.z) * P1W'(v.z);
    q1     <= q;
  end

  // Sums of the first products, rounded from Q24.
  always_comb begin
    s2[0] = S2W'(p1[0]) - S2W'(p1[1]) + S2W'(p1[2]) + (S2W'(1) <<< 23);
    s2[1] = S2W'(p1[3]) - S2W'(p1[4]) + S2W'(p1[5]) + (S2W'(1) <<< 23);
    s2[2] = S2W'(p1[6]) - S2W'(p1[7]) + S2W'(p1[8]) + (S2W'(1) <<< 23);
    s2[3] = S2W'(p1[9]) + S2W'(p1[10]) + S2W'(p1[11]) + (S2W'(1) <<< 23);
  end

  always_ff @(posedge clk) begin
    t0 <= TW'(s2[0] >>> 24);
    t1 <= TW'(s2[1] >>> 24);
    t2 <= TW'(s2[2] >>> 24);
    t3 <= TW'(s2[3] >>> 24);
    q2 <= q1;
  end

  // Second products of the t terms with the quaternion.
  always_ff @(posedge clk) begin
    p3[0]  <= P3W'(t0) * P3W'(q2.w);
    p3[1]  <= P3W'(t3) * P3W'(q2.x);
    p3[2]  <= P3W'(t1) * P3W'(q2.z);
    p3[3]  <= P3W'(t2) * P3W'(q2.y);
    p3[4]  <= P3W'(t1) * P3W'(q2.w);
    p3[5]  <= P3W'(t3) * P3W'(q2.y);
    p3[6]  <= P3W'(t2) * P3W'(q2.x);
    p3[7]  <= P3W'(t0) * P3W'(q2.z);
    p3[8]  <= P3W'(t2) * P3W'(q2.w);
    p3[9]  <= P3W'(t3) * P3W'(q2.z);
    p3[10] <= P3W'(t0) * P3W'(q2.y);
    p3[11] <= P3W'(t1) * P3W'(q2.x);
  end

  // Final sums, rounded from 2^32 and saturated to the output width.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s4[k] = S4W'(p3[4*k]) + S4W'(p3[4*k+1]) + S4W'(p3[4*k+2]) - S4W'(p3[4*k+3])
              + (S4W'(1) <<< 31);
      r4[k] = s4[k] >>> 32;
      if (r4[k] > HI) begin
        o4[k] = OUT_W'(HI);
      end else if (r4[k] < LO) begin
        o4[k] = OUT_W'(LO);
      end else begin
        o4[k] = OUT_W'(r4[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    ox <= o4[0];
    oy <= o4[1];
    oz <= o4[2];
  end

endmodule

@@ src/eqbt_checker.sv @@
// ----------------------------------------------------------------------------
// eqbt_checker
// Port-level checks of the body twist unit, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eqbt_checker #(
  parameter int CORDIC_STAGES = eqbt_pkg::CORDIC_STAGES_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [15:0] quat_x,
  input logic signed [15:0] quat_y,
  input logic signed [15:0] quat_z,
  input logic signed [15:0] quat_w
);
  import eqbt_pkg::*;

  localparam int LAT = CORDIC_STAGES + 9;
  localparam logic signed [15:0] QUAT_MIN = 16'sh8000;

  logic quat_at_min;

  // Any component sitting on the most negative code.
  assign quat_at_min = (quat_x == QUAT_MIN) || (quat_y == QUAT_MIN) ||
                       (quat_z == QUAT_MIN) || (quat_w == QUAT_MIN);

  // Every result traces back to a transaction taken a fixed latency earlier.
  `EQBT_CHECK(a_done_latency, done |-> $past(start && !busy, LAT), "result without transaction")

  // Saturation keeps every component off the most negative code.
  `EQBT_CHECK(a_quat_sat, done |-> !quat_at_min, "quaternion not saturated")

  // Reset flushes the pipeline.
  `EQBT_CHECK_RST(a_reset_flush, rst |=> !done, "result after reset")

  // Outside reset the unit is always ready.
  `EQBT_CHECK(a_never_busy, !busy, "busy outside reset")

endmodule

bind euler_to_quaternion_body_twist_unit eqbt_checker #(
  .CORDIC_STAGES (CORDIC_STAGES)
) u_eqbt_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .quat_x (quat_x),
  .quat_y (quat_y),
  .quat_z (quat_z),
  .quat_w (quat_w)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pose-to-body-twist unit testbench
// Drives pose samples through the command interface with random gaps and
// checks every quaternion and body-frame vector against a bit-true model
// of the conversion that is kept inside this bench.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_SAMPLES = 450;
  localparam int NUM_STAGES     = 16;

  typedef struct {
    logic signed [15:0] roll, pitch, yaw;
    logic signed [16:0] vx, vy, vz;
    logic signed [17:0] wx, wy, wz;
    bit                 wait_drain;
  } pose_t;

  typedef struct {
    logic signed [15:0] qx, qy, qz, qw;
    logic signed [17:0] bvx, bvy, bvz;
    logic signed [19:0] brx, bry, brz;
  } twist_t;

  logic clk, rst, start, busy, done;
  logic signed [15:0] roll_deg, pitch_deg, yaw_deg;
  logic signed [16:0] vel_x, vel_y, vel_z;
  logic signed [17:0] rate_x, rate_y, rate_z;
  logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
  logic signed [17:0] body_vel_x, body_vel_y, body_vel_z;
  logic signed [19:0] body_rate_x, body_rate_y, body_rate_z;

  pose_t  pending_poses[$];
  twist_t expected_twists[$];
  pose_t  cur_pose;
  int     n_accepted = 0;
  int     n_errors = 0;
  int     quiet_cycles = 0;
  int     idle_pct;
  bit     send_now;

  euler_to_quaternion_body_twist_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .roll_deg(roll_deg), .pitch_deg(pitch_deg), .yaw_deg(yaw_deg),
    .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
    .rate_x(rate_x), .rate_y(rate_y), .rate_z(rate_z),
    .done(done), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
    .body_vel_x(body_vel_x), .body_vel_y(body_vel_y), .body_vel_z(body_vel_z),
    .body_rate_x(body_rate_x), .body_rate_y(body_rate_y), .body_rate_z(body_rate_z)
  );

  // Clock generation.
  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Division by a power of two, rounded half up.
  function automatic longint round_shift(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint q30_mul(input longint a, input longint b);
    return round_shift(a * b, 30);
  endfunction

  // Angle in 1/128 degree to half angle in binary turns, ties away from zero.
  function automatic logic [31:0] angle_to_half_turn(input longint a);
    longint n2, h;
    n2 = a * (longint'(1) << 22);
    h = n2 >= 0 ? (n2 + 45) / 90 : -((-n2 + 45) / 90);
    return h[31:0];
  endfunction

  // Cosine and sine of a half angle in Q30, with quadrant folding.
  function automatic void half_angle_trig(input logic [31:0] turn, output longint c,
                                          output longint s);
    longint x, y, z, dx, dy;
    logic [31:0] atan_tab [24];
    logic [31:0] tw;
    bit flip;
    atan_tab = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                 32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                 32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
                 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    tw = turn;
    flip = (tw[31:30] == 2'b01) || (tw[31:30] == 2'b10);
    if (flip) tw[31] = ~tw[31];
    x = 64'h26DD3B6A;
    y = 0;
    z = longint'(signed'(tw));
    for (int i = 0; i < NUM_STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_tab[i]);
      end else begin
        x += dx; y -= dy; z += longint'(atan_tab[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Rotates a vector into the body frame through the conjugate quaternion.
  function automatic void vec_to_body_frame(input longint q[4], input longint v[3],
                                            output longint o[3]);
    longint t0, t1, t2, t3;
    t0 = round_shift(q[3] * v[0] - q[1] * v[2] + q[2] * v[1], 24);
    t1 = round_shift(q[3] * v[1] - q[2] * v[0] + q[0] * v[2], 24);
    t2 = round_shift(q[3] * v[2] - q[0] * v[1] + q[1] * v[0], 24);
    t3 = round_shift(q[0] * v[0] + q[1] * v[1] + q[2] * v[2], 24);
    o[0] = round_shift(t0 * q[3] + t3 * q[0] + t1 * q[2] - t2 * q[1], 32);
    o[1] = round_shift(t1 * q[3] + t3 * q[1] + t2 * q[0] - t0 * q[2], 32);
    o[2] = round_shift(t2 * q[3] + t3 * q[2] + t0 * q[1] - t1 * q[0], 32);
  endfunction

  // Computes the quaternion and body twist that one pose sample yields.
  function automatic twist_t pose_to_twist(input pose_t p);
    twist_t r;
    longint cr, sr, cp, sp, cy, sy, a, b;
    longint q[4], q24[4], v[3], w[3], ov[3], ow[3];
    longint qs[4];
    half_angle_trig(angle_to_half_turn(longint'(p.roll)), cr, sr);
    half_angle_trig(angle_to_half_turn(-longint'(p.pitch)), cp, sp);
    half_angle_trig(angle_to_half_turn(-longint'(p.yaw)), cy, sy);
    a = q30_mul(cr, cp);
    b = q30_mul(sr, sp);
    q[3] = q30_mul(a, cy) + q30_mul(b, sy);
    q[2] = q30_mul(a, sy) - q30_mul(b, cy);
    a = q30_mul(sr, cp);
    b = q30_mul(cr, sp);
    q[0] = q30_mul(a, cy) - q30_mul(b, sy);
    q[1] = q30_mul(b, cy) + q30_mul(a, sy);
    for (int k = 0; k < 4; k++) begin
      qs[k] = clamp(round_shift(q[k], 15), -32767, 32767);
      q24[k] = round_shift(q[k], 6);
    end
    v[0] = longint'(p.vx) * 256;
    v[1] = -longint'(p.vy) * 256;
    v[2] = longint'(p.vz) * 256;
    w[0] = round_shift(longint'(p.wx) * 64'sd9595049034, 24);
    w[1] = round_shift(-longint'(p.wy) * 64'sd9595049034, 24);
    w[2] = round_shift(-longint'(p.wz) * 64'sd9595049034, 24);
    vec_to_body_frame(q24, v, ov);
    vec_to_body_frame(q24, w, ow);
    r.qx = qs[0][15:0]; r.qy = qs[1][15:0]; r.qz = qs[2][15:0]; r.qw = qs[3][15:0];
    r.bvx = 18'(clamp(ov[0], -131072, 131071));
    r.bvy = 18'(clamp(ov[1], -131072, 131071));
    r.bvz = 18'(clamp(ov[2], -131072, 131071));
    r.brx = 20'(clamp(ow[0], -524288, 524287));
    r.bry = 20'(clamp(ow[1], -524288, 524287));
    r.brz = 20'(clamp(ow[2], -524288, 524287));
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    n_errors++;
    $display("MISMATCH %0t: %s got %0d expected %0d", $realtime, field, got, want);
  endtask

  function automatic pose_t make_pose(input int r, input int p, input int y,
                                      input int vx, input int vy, input int vz,
                                      input int wx, input int wy, input int wz);
    pose_t s;
    s.roll = 16'(r); s.pitch = 16'(p); s.yaw = 16'(y);
    s.vx = 17'(vx); s.vy = 17'(vy); s.vz = 17'(vz);
    s.wx = 18'(wx); s.wy = 18'(wy); s.wz = 18'(wz);
    s.wait_drain = 1'b0;
    return s;
  endfunction

  // Random sample: mostly within the nominal angle range, some with any bits.
  function automatic pose_t random_pose();
    pose_t s;
    s = make_pose($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom);
    if ($urandom_range(99) < 60) begin
      s.roll  = 16'($urandom_range(46080) - 23040);
      s.pitch = 16'($urandom_range(46080) - 23040);
      s.yaw   = 16'($urandom_range(46080) - 23040);
    end
    return s;
  endfunction

  // Driver: records each accepted transaction and presents the next sample.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      roll_deg <= '0; pitch_deg <= '0; yaw_deg <= '0;
      vel_x <= '0; vel_y <= '0; vel_z <= '0;
      rate_x <= '0; rate_y <= '0; rate_z <= '0;
    end else begin
      if (start && !busy) begin
        expected_twists.push_back(pose_to_twist(cur_pose));
        n_accepted++;
      end
      idle_pct = n_accepted < 150 ? 6 : (n_accepted < 300 ? 51 : 0);
      send_now = 1'b0;
      if (pending_poses.size() > 0) begin
        if (!(pending_poses[0].wait_drain && expected_twists.size() > 0)
            && $urandom_range(99) >= idle_pct)
          send_now = 1'b1;
      end
      if (send_now) begin
        cur_pose = pending_poses.pop_front();
        roll_deg <= cur_pose.roll; pitch_deg <= cur_pose.pitch; yaw_deg <= cur_pose.yaw;
        vel_x <= cur_pose.vx; vel_y <= cur_pose.vy; vel_z <= cur_pose.vz;
        rate_x <= cur_pose.wx; rate_y <= cur_pose.wy; rate_z <= cur_pose.wz;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compares each result against the oldest expectation.
  always @(posedge clk) begin
    twist_t e;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (start && !busy) quiet_cycles = 0;
      if (done) begin
        quiet_cycles = 0;
        if (expected_twists.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          e = expected_twists.pop_front();
          if (quat_x !== e.qx) report_mismatch("quat_x", quat_x, e.qx);
          if (quat_y !== e.qy) report_mismatch("quat_y", quat_y, e.qy);
          if (quat_z !== e.qz) report_mismatch("quat_z", quat_z, e.qz);
          if (quat_w !== e.qw) report_mismatch("quat_w", quat_w, e.qw);
          if (body_vel_x !== e.bvx) report_mismatch("body_vel_x", body_vel_x, e.bvx);
          if (body_vel_y !== e.bvy) report_mismatch("body_vel_y", body_vel_y, e.bvy);
          if (body_vel_z !== e.bvz) report_mismatch("body_vel_z", body_vel_z, e.bvz);
          if (body_rate_x !== e.brx) report_mismatch("body_rate_x", body_rate_x, e.brx);
          if (body_rate_y !== e.bry) report_mismatch("body_rate_y", body_rate_y, e.bry);
          if (body_rate_z !== e.brz) report_mismatch("body_rate_z", body_rate_z, e.brz);
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL euler_to_quaternion_body_twist_unit");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    pose_t s;
    rst = 1'b1;

    // Directed samples: identity, field extremes, quadrant edges and wrap-around.
    pending_poses.push_back(make_pose(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_poses.push_back(make_pose(0, 0, 0, 256, 256, 256, 64, 64, 64));
    pending_poses.push_back(make_pose(23040, 0, 0, 65535, 0, 0, 131071, 0, 0));
    pending_poses.push_back(make_pose(-23040, 0, 0, -65536, 0, 0, -131072, 0, 0));
    pending_poses.push_back(make_pose(0, 23040, 0, 0, 65535, 0, 0, 131071, 0));
    pending_poses.push_back(make_pose(0, -23040, 0, 0, -65536, 0, 0, -131072, 0));
    pending_poses.push_back(make_pose(0, 0, 23040, 0, 0, 65535, 0, 0, 131071));
    pending_poses.push_back(make_pose(0, 0, -23040, 0, 0, -65536, 0, 0, -131072));
    pending_poses.push_back(make_pose(11520, 11520, 11520, 1000, -1000, 500, 5760, -5760, 100));
    pending_poses.push_back(make_pose(-11520, -11520, -11520, 65535, 65535, 65535,
                                      131071, 131071, 131071));
    pending_poses.push_back(make_pose(32767, 32767, 32767, -65536, -65536, -65536,
                                      -131072, -131072, -131072));
    pending_poses.push_back(make_pose(-32768, -32768, -32768, 65535, -65536, 65535,
                                      131071, -131072, 131071));
    pending_poses.push_back(make_pose(23039, -23039, 11519, 12345, -2345, 345, 7, -7, 1));
    pending_poses.push_back(make_pose(11521, -11521, 46080 - 32768, -1, -1, -1, -1, -1, -1));
    pending_poses.push_back(make_pose(5760, 17280, -17280, 300, 400, 500, 600, 700, 800));
    pending_poses.push_back(make_pose(1, -1, 1, 1, 1, 1, 1, 1, 1));
    s = make_pose(5000, -3000, 20000, 30000, -30000, 100, 90000, -90000, 45000);
    s.wait_drain = 1'b1;
    pending_poses.push_back(s);
    pending_poses.push_back(make_pose(-5760, 5760, 0, 0, 0, 0, 131071, 131071, -131072));

    for (int i = 0; i < RANDOM_SAMPLES; i++) begin
      s = random_pose();
      // Occasionally hold off until the pipeline has emptied.
      if (i == 100 || i == 260 || i == 400) s.wait_drain = 1'b1;
      pending_poses.push_back(s);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_poses.size() > 0 || start || expected_twists.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0 && expected_twists.size() == 0)
      $display("PASS euler_to_quaternion_body_twist_unit");
    else
      $display("FAIL euler_to_quaternion_body_twist_unit");
    $finish;
  end

endmodule
